FILE: design/bmm_pkg.sv
// shared types and constants of the blocked matrix multiplier
package bmm_pkg;

   localparam int BLOCK_SIZE_DEF = 12;
   localparam int MAX_BLOCKS_DEF = 8;

   // fixed by the word formats
   localparam int ELEMENT_BITS = 16;
   localparam int INDEX_W      = 7;
   localparam int ACC_W        = 48;
   localparam int CFG_W        = 4;
   localparam int CSR_INDEX_W  = 2;
   // holds a dimension of up to 16 blocks of 16
   localparam int LIMIT_W      = 9;

   localparam logic [1:0] OP_WR_LEFT  = 2'd0;
   localparam logic [1:0] OP_WR_RIGHT = 2'd1;
   localparam logic [1:0] OP_COMPUTE  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_A_ROWS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_B_COLS = 2'd2;

   typedef enum logic [1:0] {
      CMD_WR_LEFT,
      CMD_WR_RIGHT,
      CMD_COMPUTE,
      CMD_RANGE_ERR
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]                      opcode;
      logic [INDEX_W-1:0]              row_index;
      logic [INDEX_W-1:0]              col_index;
      logic signed [ELEMENT_BITS-1:0]  element_value;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]       out_row;
      logic [INDEX_W-1:0]       out_col;
      logic signed [ACC_W-1:0]  product_value;
      logic                     index_error;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type                    kind;
      logic [INDEX_W-1:0]              row;
      logic [INDEX_W-1:0]              col;
      logic signed [ELEMENT_BITS-1:0]  value;
      logic [LIMIT_W-1:0]              inner;
   } cmd_type;

endpackage

FILE: design/bmm_fifo.sv
// small register queue used between front and back and at the result side
module bmm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/bmm_front.sv
// front end: size registers, word decode and range checks
module bmm_front #(
   parameter int BLOCK_SIZE = 12,
   parameter int MAX_BLOCKS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  bmm_pkg::req_type                  req_data,
   output logic                              req_full,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bmm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bmm_pkg::CFG_W-1:0]         csr_data,
   input  logic                              cmd_full,
   output logic                              cmd_push,
   output bmm_pkg::cmd_type                  cmd_word
);

   import bmm_pkg::*;

   localparam int DIM = BLOCK_SIZE * MAX_BLOCKS;

   function automatic logic [LIMIT_W-1:0] blocks_to_limit(input logic [CFG_W-1:0] v);
      logic [CFG_W:0] b;
      b = {1'b0, v};
      if (b == '0) b = (CFG_W + 1)'(1);
      if (b > (CFG_W + 1)'(MAX_BLOCKS)) b = (CFG_W + 1)'(MAX_BLOCKS);
      return LIMIT_W'(b * BLOCK_SIZE);
   endfunction

   logic [LIMIT_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [LIMIT_W-1:0] row_l, col_l;
   logic               accept, in_store, in_result;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;

   assign row_l     = LIMIT_W'(req_data.row_index);
   assign col_l     = LIMIT_W'(req_data.col_index);
   assign in_store  = (row_l < LIMIT_W'(DIM)) && (col_l < LIMIT_W'(DIM));
   assign in_result = (row_l < rows_ff) && (col_l < cols_ff);

   // only the effective sizes are kept, the raw bits are never read back
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= LIMIT_W'(BLOCK_SIZE);
         inner_ff <= LIMIT_W'(BLOCK_SIZE);
         cols_ff  <= LIMIT_W'(BLOCK_SIZE);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_A_ROWS: rows_ff  <= blocks_to_limit(csr_data);
            CSR_INNER:  inner_ff <= blocks_to_limit(csr_data);
            CSR_B_COLS: cols_ff  <= blocks_to_limit(csr_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd_push       = 1'b0;
      cmd_word.kind  = CMD_WR_LEFT;
      cmd_word.row   = req_data.row_index;
      cmd_word.col   = req_data.col_index;
      cmd_word.value = req_data.element_value;
      cmd_word.inner = inner_ff;
      unique case (req_data.opcode)
         OP_WR_LEFT: begin
            cmd_word.kind = CMD_WR_LEFT;
            cmd_push      = accept && in_store;
         end
         OP_WR_RIGHT: begin
            cmd_word.kind = CMD_WR_RIGHT;
            cmd_push      = accept && in_store;
         end
         OP_COMPUTE: begin
            cmd_word.kind = in_result ? CMD_COMPUTE : CMD_RANGE_ERR;
            cmd_push      = accept;
         end
         default: ;
      endcase
   end

endmodule

FILE: design/bmm_back.sv
// back end: element stores and the multiply-accumulate sequencer
module bmm_back #(
   parameter int BLOCK_SIZE = 12,
   parameter int MAX_BLOCKS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_empty,
   input  bmm_pkg::cmd_type    cmd_word,
   output logic                cmd_pop,
   input  logic                rsp_full,
   output logic                rsp_push,
   output bmm_pkg::rsp_type    rsp_word
);

   import bmm_pkg::*;

   localparam int DIM    = BLOCK_SIZE * MAX_BLOCKS;
   localparam int DEPTH  = DIM * DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PROD_W = 2 * ELEMENT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   logic signed [ELEMENT_BITS-1:0] left_mem  [DEPTH];
   logic signed [ELEMENT_BITS-1:0] right_mem [DEPTH];

   state_type                state_ff, state_in;
   logic [LIMIT_W-1:0]       k_ff, k_in;
   logic [LIMIT_W-1:0]       last_ff, last_in;
   logic [ADDR_W-1:0]        l_addr_ff, l_addr_in;
   logic [ADDR_W-1:0]        r_addr_ff, r_addr_in;
   logic [INDEX_W-1:0]       row_ff, row_in;
   logic [INDEX_W-1:0]       col_ff, col_in;
   logic                     s1_valid_ff, s1_valid_in, s1_last_ff, s1_last_in;
   logic                     s2_valid_ff, s2_valid_in, s2_last_ff, s2_last_in;
   logic                     done_ff, done_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic signed [ELEMENT_BITS-1:0] l_rdata_ff, r_rdata_ff;
   logic                           rd_en, we_left, we_right;
   logic [ADDR_W-1:0]              wr_addr, row_base;

   assign row_base = ADDR_W'(cmd_word.row) * ADDR_W'(DIM);
   assign wr_addr  = row_base + ADDR_W'(cmd_word.col);
   assign rd_en    = (state_ff == ST_RUN);

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      last_in   = last_ff;
      l_addr_in = l_addr_ff;
      r_addr_in = r_addr_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp_word  = '0;
      we_left   = 1'b0;
      we_right  = 1'b0;

      // read data -> product -> accumulate, one stage each
      s1_valid_in = 1'b0;
      s1_last_in  = 1'b0;
      s2_valid_in = s1_valid_ff;
      s2_last_in  = s1_last_ff;
      prod_in     = l_rdata_ff * r_rdata_ff;
      acc_in      = s2_valid_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      done_in     = done_ff || (s2_valid_ff && s2_last_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               unique case (cmd_word.kind)
                  CMD_WR_LEFT: begin
                     cmd_pop = 1'b1;
                     we_left = 1'b1;
                  end
                  CMD_WR_RIGHT: begin
                     cmd_pop  = 1'b1;
                     we_right = 1'b1;
                  end
                  CMD_RANGE_ERR: begin
                     if (!rsp_full) begin
                        cmd_pop              = 1'b1;
                        rsp_push             = 1'b1;
                        rsp_word.out_row     = cmd_word.row;
                        rsp_word.out_col     = cmd_word.col;
                        rsp_word.index_error = 1'b1;
                     end
                  end
                  CMD_COMPUTE: begin
                     // result slot is reserved here, only this side fills it
                     if (!rsp_full) begin
                        cmd_pop   = 1'b1;
                        row_in    = cmd_word.row;
                        col_in    = cmd_word.col;
                        k_in      = '0;
                        last_in   = cmd_word.inner - LIMIT_W'(1);
                        l_addr_in = row_base;
                        r_addr_in = ADDR_W'(cmd_word.col);
                        acc_in    = '0;
                        done_in   = 1'b0;
                        state_in  = ST_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            s1_valid_in = 1'b1;
            s1_last_in  = (k_ff == last_ff);
            k_in        = k_ff + LIMIT_W'(1);
            l_addr_in   = l_addr_ff + ADDR_W'(1);
            r_addr_in   = r_addr_ff + ADDR_W'(DIM);
            if (k_ff == last_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (done_ff) begin
               rsp_push               = 1'b1;
               rsp_word.out_row       = row_ff;
               rsp_word.out_col       = col_ff;
               rsp_word.product_value = acc_ff;
               done_in                = 1'b0;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         done_ff     <= done_in;
      end
      k_ff       <= k_in;
      last_ff    <= last_in;
      l_addr_ff  <= l_addr_in;
      r_addr_ff  <= r_addr_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      s1_last_ff <= s1_last_in;
      s2_last_ff <= s2_last_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (we_left) begin
         left_mem[wr_addr] <= cmd_word.value;
      end
      if (rd_en) begin
         l_rdata_ff <= left_mem[l_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (we_right) begin
         right_mem[wr_addr] <= cmd_word.value;
      end
      if (rd_en) begin
         r_rdata_ff <= right_mem[r_addr_ff];
      end
   end

endmodule

FILE: design/blocked_matrix_multiply.sv
// top level of the blocked matrix multiplier
// Words go into a four-entry command queue: a load word has the back end write its element,
// and a compute word for an element inside the configured size sums inner_blocks*BLOCK_SIZE
// products (12 to 96 at the defaults) on the single multiply-accumulate unit, fed by one
// read port on each element store, through the read, product and accumulate registers;
// an index outside the configured size answers without a dot product, with index_error set.
// Loads beyond the store and opcode 3 are dropped at the input. Results leave through a
// two-entry queue. The element stores are not cleared: an element must be written before a
// compute word reads it.
module blocked_matrix_multiply #(
   parameter int BLOCK_SIZE = bmm_pkg::BLOCK_SIZE_DEF,
   parameter int MAX_BLOCKS = bmm_pkg::MAX_BLOCKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  bmm_pkg::req_type                  req_data,
   output logic                              req_full,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output bmm_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bmm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bmm_pkg::CFG_W-1:0]         csr_data
);

   import bmm_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cmd_type           cmd_in_word, cmd_out_word;
   logic [CMD_W-1:0]  cmd_out_bits;
   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
   rsp_type           rsp_word;
   logic [RSP_W-1:0]  rsp_out_bits;
   logic              rsp_push, rsp_full;

   bmm_front #(
      .BLOCK_SIZE (BLOCK_SIZE),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_word  (cmd_in_word)
   );

   bmm_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (4)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_word),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_bits),
      .empty     (cmd_empty)
   );

   assign cmd_out_word = cmd_type'(cmd_out_bits);

   bmm_back #(
      .BLOCK_SIZE (BLOCK_SIZE),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_word  (cmd_out_word),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word)
   );

   bmm_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_word),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out_bits),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_out_bits);

`ifndef SYNTHESIS
   // the back end reserves the result slot before it starts a dot product
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command taken from an empty queue");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_word.index_error) |-> (rsp_word.product_value == '0))
      else $error("range error result carries a nonzero product");
`endif

endmodule
